FILE: rtl/fvn_pkg.sv
package fvn_pkg;

  // Field and register widths
  localparam int PIX_W   = 10;
  localparam int SCALE_W = 16;
  localparam int MH_W    = 8;
  localparam int OUT_W   = 16;
  localparam int CFG_W   = 16;
  localparam int B_W     = PIX_W + SCALE_W;   // scaled coordinate, Q.16
  localparam int T_W     = 16;                // lattice fraction, Q0.16
  localparam int IDX_W   = 32;                // lattice index, wraps
  localparam int VAL_W   = 32;                // corner value, signed Q.30

  // Configuration register indexes
  localparam logic CFG_INV_SCALE  = 1'b0;
  localparam logic CFG_MAX_HEIGHT = 1'b1;

  localparam logic [SCALE_W-1:0] INV_SCALE_RST  = 16'd546;
  localparam logic [MH_W-1:0]    MAX_HEIGHT_RST = 8'd60;

  // Defaults for the top-level parameters
  localparam int MAP_WIDTH_DEF  = 1024;
  localparam int MAP_HEIGHT_DEF = 1024;
  localparam int OCTAVES_DEF    = 4;

  // Integer hash constants
  localparam logic [IDX_W-1:0] HASH_ROW  = 32'd57;
  localparam logic [IDX_W-1:0] HASH_C1   = 32'd15731;
  localparam logic [IDX_W-1:0] HASH_C2   = 32'd789221;
  localparam logic [IDX_W-1:0] HASH_C3   = 32'd1376312589;
  localparam logic [IDX_W-1:0] HASH_MASK = 32'h7fff_ffff;
  localparam logic [IDX_W-1:0] VAL_ONE   = 32'h4000_0000;

  // Pipeline registers from scaled coordinate to octave value (hash 4, blend 4)
  localparam int OCT_LAT = 8;

endpackage

FILE: rtl/fvn_hash.sv
module fvn_hash
  import fvn_pkg::*;
(
  input  logic                    clk,
  input  logic [IDX_W-1:0]        ix,
  input  logic [IDX_W-1:0]        iy,
  output logic signed [VAL_W-1:0] value
);

  logic [IDX_W-1:0] n0;
  logic [IDX_W-1:0] n1_r, n2_r, n3_r;
  logic [IDX_W-1:0] sq_r;
  logic [IDX_W-1:0] p_r;
  logic [IDX_W-1:0] m;
  logic signed [VAL_W-1:0] value_r;

  assign n0 = ix + iy * HASH_ROW;

  always_ff @(posedge clk) begin
    n1_r    <= (n0 << 13) ^ n0;
    sq_r    <= n1_r * n1_r;
    n2_r    <= n1_r;
    p_r     <= sq_r * HASH_C1 + HASH_C2;
    n3_r    <= n2_r;
    value_r <= $signed(VAL_ONE - m);
  end

  assign m     = (n3_r * p_r + HASH_C3) & HASH_MASK;
  assign value = value_r;

endmodule

FILE: rtl/fvn_octave.sv
module fvn_octave
  import fvn_pkg::*;
#(
  parameter int OCT_IDX = 0
) (
  input  logic                    clk,
  input  logic [B_W-1:0]          bx,
  input  logic [B_W-1:0]          by,
  output logic signed [VAL_W-1:0] value
);

  localparam int CX_W = B_W + OCT_IDX;

  logic [CX_W-1:0]  cx, cy;
  logic [IDX_W-1:0] ix0, ix1, iy0, iy1;
  logic [2*T_W-1:0] t_r [6];
  logic signed [VAL_W-1:0] v1, v2, v3, v4;
  logic signed [VAL_W:0]   d0, d1, dy;
  logic signed [VAL_W+T_W+1:0] prod0_r, prod1_r, prody_r;
  logic signed [VAL_W-1:0] a0_r, a1_r, r0_r, r1_r, ry_r, value_r;

  assign cx  = CX_W'(bx) << OCT_IDX;
  assign cy  = CX_W'(by) << OCT_IDX;
  assign ix0 = IDX_W'(cx >> T_W);
  assign iy0 = IDX_W'(cy >> T_W);
  assign ix1 = ix0 + 1'b1;
  assign iy1 = iy0 + 1'b1;

  fvn_hash u_h1 (.clk(clk), .ix(ix0), .iy(iy0), .value(v1));
  fvn_hash u_h2 (.clk(clk), .ix(ix1), .iy(iy0), .value(v2));
  fvn_hash u_h3 (.clk(clk), .ix(ix0), .iy(iy1), .value(v3));
  fvn_hash u_h4 (.clk(clk), .ix(ix1), .iy(iy1), .value(v4));

  assign d0 = {v2[VAL_W-1], v2} - {v1[VAL_W-1], v1};
  assign d1 = {v4[VAL_W-1], v4} - {v3[VAL_W-1], v3};
  assign dy = {r1_r[VAL_W-1], r1_r} - {r0_r[VAL_W-1], r0_r};

  always_ff @(posedge clk) begin
    // fractions ride alongside the hash and row blend
    t_r[0] <= {cx[T_W-1:0], cy[T_W-1:0]};
    for (int i = 1; i < 6; i++) begin
      t_r[i] <= t_r[i-1];
    end
    prod0_r <= $signed({1'b0, t_r[3][2*T_W-1:T_W]}) * d0;
    prod1_r <= $signed({1'b0, t_r[3][2*T_W-1:T_W]}) * d1;
    a0_r    <= v1;
    a1_r    <= v3;
    r0_r    <= a0_r + VAL_W'(prod0_r >>> T_W);
    r1_r    <= a1_r + VAL_W'(prod1_r >>> T_W);
    prody_r <= $signed({1'b0, t_r[5][T_W-1:0]}) * dy;
    ry_r    <= r0_r;
    value_r <= ry_r + VAL_W'(prody_r >>> T_W);
  end

  assign value = value_r;

endmodule

FILE: rtl/fractal_value_noise_height_unit.sv
// Fractal value-noise terrain height unit.
//
// Input: pulse start with in_pixel_x / in_pixel_y; the item is taken at any
// edge where start is high and busy is low. busy is never raised, so one item
// may enter in every cycle.
// Output: out_valid marks out_height_q8_8 (unsigned Q8.8) for exactly one
// cycle. Results leave in input order.
// Throughput is one item per cycle: every octave has its own lane of four
// hash pipelines and three blend multipliers, so nothing is shared.
// The receiver cannot hold results off and the pipeline never stalls.
// Configuration: cfg_we writes cfg_wdata to the register at cfg_index
// (0 inverse hill size Q0.16, 1 maximum height). Write only while idle.
// Reset clears the valid pipeline and loads the register defaults (546, 60);
// items already in flight are dropped.
module fractal_value_noise_height_unit
  import fvn_pkg::*;
#(
  parameter int MAP_WIDTH  = MAP_WIDTH_DEF,
  parameter int MAP_HEIGHT = MAP_HEIGHT_DEF,
  parameter int OCTAVES    = OCTAVES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [PIX_W-1:0] in_pixel_x,
  input  logic [PIX_W-1:0] in_pixel_y,
  output logic             out_valid,
  output logic [OUT_W-1:0] out_height_q8_8,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int WEIGHT_TOTAL = (1 << OCTAVES) - 1;
  localparam int SUM_W   = VAL_W + OCTAVES;        // signed weighted sum
  localparam int NUM_W   = VAL_W - 1 + OCTAVES;    // sum shifted to non-negative
  localparam int SCL_W   = NUM_W + MH_W;
  localparam int QW      = OCTAVES + 16;           // quotient before / W
  localparam int RECIP_K = 26;
  localparam int RECIP_W = RECIP_K + 1;
  localparam int LAT     = 2 + OCT_LAT + 3;
  localparam logic signed [SUM_W-1:0] SUM_OFFSET = SUM_W'(WEIGHT_TOTAL) << 30;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'd1 << RECIP_K) / WEIGHT_TOTAL);
  localparam logic [QW-1:0] W_Q = QW'(WEIGHT_TOTAL);

  logic [SCALE_W-1:0] inv_scale_r;
  logic [MH_W-1:0]    max_height_r;
  logic [LAT-1:0]     vld_r;
  logic               in_take;

  logic [PIX_W-1:0] px_nxt, py_nxt, px_r, py_r;
  logic [B_W-1:0]   bx_r, by_r;
  logic signed [VAL_W-1:0] oct_val [OCTAVES];
  logic signed [SUM_W-1:0] sum;
  logic [NUM_W-1:0]         num_r;
  logic [SCL_W-1:0]         scaled_r;
  logic [QW-1:0]            q, q_r;
  logic [QW+RECIP_W-1:0]    prod_r;
  logic [QW-1:0]            est, estw, est_fin;
  logic                     out_valid_r;
  logic [OUT_W-1:0]         height_r;

  assign busy    = 1'b0;
  assign in_take = start & ~busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_scale_r  <= INV_SCALE_RST;
      max_height_r <= MAX_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INV_SCALE:  inv_scale_r  <= cfg_wdata[SCALE_W-1:0];
        CFG_MAX_HEIGHT: max_height_r <= cfg_wdata[MH_W-1:0];
        default: ;
      endcase
    end
  end

  // Valid bits advance with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[LAT-2:0], in_take};
      out_valid_r <= vld_r[LAT-1];
    end
  end

  // Clamp pixels to the map
  always_comb begin
    px_nxt = in_pixel_x;
    py_nxt = in_pixel_y;
    if (32'(in_pixel_x) > MAP_WIDTH - 1)  px_nxt = PIX_W'(MAP_WIDTH - 1);
    if (32'(in_pixel_y) > MAP_HEIGHT - 1) py_nxt = PIX_W'(MAP_HEIGHT - 1);
  end

  always_ff @(posedge clk) begin
    px_r <= px_nxt;
    py_r <= py_nxt;
    bx_r <= B_W'(px_r) * inv_scale_r;
    by_r <= B_W'(py_r) * inv_scale_r;
  end

  // One lane per octave; frequency doubles lane by lane
  for (genvar o = 0; o < OCTAVES; o++) begin : g_oct
    fvn_octave #(.OCT_IDX(o)) u_oct (
      .clk  (clk),
      .bx   (bx_r),
      .by   (by_r),
      .value(oct_val[o])
    );
  end

  // Weighted sum: octave o carries weight 2^(OCTAVES-1-o); offset maps to >= 0
  always_comb begin
    sum = SUM_OFFSET;
    for (int o = 0; o < OCTAVES; o++) begin
      sum = sum + (SUM_W'(oct_val[o]) <<< (OCTAVES - 1 - o));
    end
  end

  assign q = QW'(scaled_r >> 23);

  // Divide by the weight total: reciprocal estimate, then one correction
  always_comb begin
    est     = QW'(prod_r >> RECIP_K);
    estw    = QW'(est * W_Q);
    est_fin = est;
    if (q_r - estw >= W_Q) est_fin = est + 1'b1;
  end

  always_ff @(posedge clk) begin
    num_r    <= NUM_W'(sum);
    scaled_r <= SCL_W'(num_r) * max_height_r;
    q_r      <= q;
    prod_r   <= q * RECIP;
    // saturate at the top of Q8.8
    height_r <= (est_fin > QW'(16'hFFFF)) ? 16'hFFFF : est_fin[OUT_W-1:0];
  end

  assign out_valid       = out_valid_r;
  assign out_height_q8_8 = height_r;

endmodule

FILE: verif/fractal_value_noise_height_unit_test.sv
module fractal_value_noise_height_unit_test;
  import fvn_pkg::*;

  localparam int NOISE_OCTAVES = OCTAVES_DEF;
  localparam int PIPE_LAT      = 14;
  localparam int RANDOM_ITEMS  = 1530;

  // Height predictor and pending-height store.
  class height_board;
    logic [SCALE_W-1:0] inv_scale;
    logic [MH_W-1:0]    max_h;
    logic [OUT_W-1:0]   pending_heights[$];
    int                 mismatches;
    int                 matched;

    function void reset_regs();
      inv_scale = INV_SCALE_RST;
      max_h     = MAX_HEIGHT_RST;
    endfunction

    function void write_reg(logic idx, logic [CFG_W-1:0] data);
      if (idx == CFG_INV_SCALE) inv_scale = data[SCALE_W-1:0];
      else                      max_h     = data[MH_W-1:0];
    endfunction

    function longint lattice_val(logic [31:0] ix, logic [31:0] iy);
      logic [31:0] n;
      logic [31:0] m;
      n = ix + iy * HASH_ROW;
      n = (n << 13) ^ n;
      m = (n * (n * n * HASH_C1 + HASH_C2) + HASH_C3) & HASH_MASK;
      return longint'(VAL_ONE) - longint'({1'b0, m});
    endfunction

    // Floor division by 2^16 of a signed product.
    function longint mix(longint a, longint b, longint t);
      longint p;
      p = t * (b - a);
      return a + (p >>> 16);
    endfunction

    function longint octave_sum(logic [63:0] cx, logic [63:0] cy);
      logic [31:0] ix;
      logic [31:0] iy;
      longint tx;
      longint ty;
      ix = cx[47:16];
      iy = cy[47:16];
      tx = longint'(cx[15:0]);
      ty = longint'(cy[15:0]);
      return mix(mix(lattice_val(ix, iy), lattice_val(ix + 1, iy), tx),
                 mix(lattice_val(ix, iy + 1), lattice_val(ix + 1, iy + 1), tx), ty);
    endfunction

    // Note one accepted item: compute and queue its height.
    function void note_item(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
      logic [63:0] bx;
      logic [63:0] by;
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] h;
      longint      acc;
      longint      wt;
      acc = 0;
      bx = 64'(px) * 64'(inv_scale);
      by = 64'(py) * 64'(inv_scale);
      for (int o = 0; o < NOISE_OCTAVES; o++)
        acc += octave_sum(bx << o, by << o) * (longint'(1) << (NOISE_OCTAVES - 1 - o));
      wt  = (longint'(1) << NOISE_OCTAVES) - 1;
      num = 64'(acc + (wt << 30));
      num = num * 64'(max_h) * 64'd256;
      den = 64'(wt) << 31;
      h = num / den;
      if (h > 64'hFFFF) h = 64'hFFFF;
      pending_heights.push_back(h[OUT_W-1:0]);
    endfunction

    // Print one line per mismatch and count it.
    task report_mismatch(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_height(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] want;
      if (pending_heights.size() == 0) begin
        report_mismatch($sformatf("unexpected height %0d", got));
        return;
      end
      want = pending_heights.pop_front();
      if (got !== want)
        report_mismatch($sformatf("height got %0d want %0d", got, want));
      else
        matched++;
    endtask
  endclass

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [PIX_W-1:0] in_pixel_x;
  logic [PIX_W-1:0] in_pixel_y;
  logic             out_valid;
  logic [OUT_W-1:0] out_height_q8_8;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  height_board board;
  int          items_sent;

  fractal_value_noise_height_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_pixel_x      (in_pixel_x),
    .in_pixel_y      (in_pixel_y),
    .out_valid       (out_valid),
    .out_height_q8_8 (out_height_q8_8),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Check each height on the edge that ends its strobe cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_height(out_height_q8_8);
  end

  // Hold start and the pixel fields until the block takes the item, after a
  // random gap; the predictor is told at the accepting edge. Leave start high
  // so a following item with no gap goes straight in.
  task automatic send_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_pixel_x <= px;
    in_pixel_y <= py;
    do @(posedge clk); while (busy);
    board.note_item(px, py);
    items_sent++;
  endtask

  // Drain: drop start, wait for every pending height, then let the pipe settle.
  task automatic drain_heights();
    start <= 1'b0;
    while (board.pending_heights.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    board.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Random gap: none in a burst; else none a third of the time, else a random draw.
  function automatic int draw_gap(bit burst);
    if (burst) return 0;
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
  endfunction

  // Zero, the top value, low pixel values where the noise moves slowly, or full range.
  function automatic logic [PIX_W-1:0] draw_pixel();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return PIX_W'($urandom_range(0, 31));
      default: return PIX_W'($urandom());
    endcase
  endfunction

  initial begin
    logic [SCALE_W-1:0] scales[6];
    logic [MH_W-1:0]    heights[6];
    bit                 burst;
    board = new();
    board.reset_regs();
    board.mismatches = 0;
    board.matched    = 0;
    items_sent = 0;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_pixel_x = '0;
    in_pixel_y = '0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_INV_SCALE;
    cfg_wdata  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: corners of the map and field extremes at reset settings.
    send_pixel('0, '0, 0);
    send_pixel('1, '1, 0);
    send_pixel('1, '0, 1);
    send_pixel('0, '1, 0);
    send_pixel(10'h2AA, 10'h155, 2);
    send_pixel(10'h155, 10'h2AA, 0);
    drain_heights();

    // Zero scale collapses every sample onto lattice (0,0).
    write_cfg(CFG_INV_SCALE, 16'd0);
    send_pixel('1, 10'd517, 0);
    send_pixel(10'd3, '1, 0);
    drain_heights();
    // Largest scale with the top height, so lattice indexes reach their largest values.
    write_cfg(CFG_INV_SCALE, 16'hFFFF);
    write_cfg(CFG_MAX_HEIGHT, 16'd255);
    send_pixel('1, '1, 0);
    send_pixel(10'd1, 10'd0, 0);
    send_pixel(10'd512, 10'd1, 3);
    drain_heights();
    // Zero height, and a write wider than the register keeps its low byte.
    write_cfg(CFG_MAX_HEIGHT, 16'd0);
    send_pixel(10'd77, 10'd900, 0);
    drain_heights();
    write_cfg(CFG_MAX_HEIGHT, 16'hFF01);
    send_pixel(10'd300, 10'd40, 0);
    drain_heights();

    // Random phases, one register setting per phase; extremes included.
    scales  = '{16'd1, 16'hFFFF, 16'd546, 16'd8192, 16'h8000, 16'd0};
    heights = '{8'd1, 8'd255, 8'd60, 8'd128, 8'd0, 8'd200};
    for (int ph = 0; ph < 12; ph++) begin
      if (ph < 6) begin
        write_cfg(CFG_INV_SCALE, scales[ph]);
        write_cfg(CFG_MAX_HEIGHT, heights[ph]);
      end else begin
        write_cfg(CFG_INV_SCALE, CFG_W'($urandom()));
        write_cfg(CFG_MAX_HEIGHT, CFG_W'($urandom()));
      end
      burst = 1'b0;
      for (int i = 0; i < RANDOM_ITEMS / 12; i++) begin
        // Switch between back-to-back bursts and gappy stretches.
        if ($urandom_range(0, 19) == 0) burst = !burst;
        send_pixel(draw_pixel(), draw_pixel(), draw_gap(burst));
      end
      drain_heights();
    end

    $display("Sent %0d pixels over 17 register settings; %0d heights matched.",
             items_sent, board.matched);
    if (board.mismatches == 0)
      $display("fractal_value_noise_height_unit_test OK");
    else
      $display("fractal_value_noise_height_unit_test NOT OK");
    $finish;
  end

  initial begin
    #5000000;
    $display("Timed out with %0d heights pending.", board.pending_heights.size());
    $display("fractal_value_noise_height_unit_test NOT OK");
    $finish;
  end

endmodule

FILE: files.f
rtl/fvn_pkg.sv
rtl/fvn_hash.sv
rtl/fvn_octave.sv
rtl/fractal_value_noise_height_unit.sv
verif/fractal_value_noise_height_unit_test.sv
